### rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and codes for the delta-ordered sleep queue: command and
// result-kind codes, the stored entry layout and default sizes.
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int unsigned SDQ_DEPTH_DEF = 16;  // default number of queue slots
  localparam int unsigned SDQ_MAX_WAKES = 16;  // most wakes reported on one tick
  localparam int unsigned THREAD_W      = 8;
  localparam int unsigned DELTA_W       = 16;

  // command codes on the cmd port
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // result kinds on the wake_kind port
  localparam logic [1:0] KIND_WAKE    = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // one queue slot as stored in the slot RAM
  typedef struct packed {
    logic                timed;
    logic [DELTA_W-1:0]  delta;
    logic [THREAD_W-1:0] thread;
  } entry_t;

endpackage

### rtl/sdq_ram.sv
// ----------------------------------------------------------------------------
// sdq_ram
// Generic simple dual-port RAM: one write port and one read port per cycle,
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module sdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/sleep_delta_queue_core.sv
// ----------------------------------------------------------------------------
// sleep_delta_queue_core
// Delta-ordered sleep queue of thread ids. One slot RAM holds the entries in
// wake order; a small sequencer walks it one slot per cycle and moves slots
// through its single read and write port.
// ----------------------------------------------------------------------------
// A put to a full queue is rejected without raising busy; the reject
//   result is registered in the cycle after its transfer.
// Throughput: one command at a time; busy stays high while it runs.
// Results come one per cycle back to back, with no stall from the receiver.
// Reset: synchronous rst empties the queue; slot contents are not cleared.
module sleep_delta_queue_core
  import sdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SDQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [THREAD_W-1:0] thread_id,
  input  logic [DELTA_W-1:0]  sleep_ticks,
  input  logic                timed_wait,
  output logic                result_valid,
  output logic [THREAD_W-1:0] woken_thread,
  output logic [1:0]          wake_kind,
  output logic                last_of_run
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUT_WALK,
    S_PUT_SUCC,
    S_PUT_NEW,
    S_MOVE,
    S_TK_SCAN,
    S_TK_FIN,
    S_RM_SCAN,
    S_RM_SUCC
  } state_t;

  state_t              state;
  state_t              after_move;
  logic [CW-1:0]       count;
  logic [CW-1:0]       pos;
  logic [DELTA_W-1:0]  ticks;
  logic [THREAD_W-1:0] thr;
  logic                timed;
  entry_t              stop;
  entry_t              pend;
  logic                has_pend;
  logic [DELTA_W-1:0]  found_delta;

  // slot mover state
  logic [AW-1:0]       src;
  logic [AW-1:0]       dst;
  logic [CW-1:0]       rem;
  logic                mv_up;
  logic                mv_wr;
  logic [AW-1:0]       mv_dst;

  // RAM ports
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic [AW-1:0]       rd_addr;
  entry_t              rd_data;

  logic [CW-1:0]       pos_inc;
  logic [CW-1:0]       pos_inc2;
  logic [DELTA_W-1:0]  tk_delta;
  logic                tk_wake;
  logic [DELTA_W:0]    rm_sum;

  sdq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy     = (state != S_IDLE);
  assign pos_inc  = pos + CW'(1);
  assign pos_inc2 = pos + CW'(2);

  // tick scan: the head's delta counts down once, unless already zero
  assign tk_delta = ((pos == '0) && (rd_data.delta != '0)) ?
                    rd_data.delta - DELTA_W'(1) : rd_data.delta;
  assign tk_wake  = (tk_delta == '0) && (32'(pos) < SDQ_MAX_WAKES);

  // remove: merged delta of the successor, saturating
  assign rm_sum = {1'b0, rd_data.delta} + {1'b0, found_delta};

  // RAM address and write control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_PUT_WALK, S_RM_SCAN: begin
        rd_addr = pos_inc[AW-1:0];
      end
      S_TK_SCAN: begin
        rd_addr = pos_inc[AW-1:0];
        // head survives the tick: store its reduced delta
        if (!tk_wake && (pos == '0)) begin
          wr_en         = 1'b1;
          wr_data.delta = tk_delta;
        end
      end
      S_MOVE: begin
        rd_addr = src;
        wr_en   = mv_wr;
        wr_addr = mv_dst;
      end
      S_PUT_SUCC: begin
        wr_en         = 1'b1;
        wr_addr       = pos_inc[AW-1:0];
        wr_data       = stop;
        wr_data.delta = stop.delta - ticks;
      end
      S_PUT_NEW: begin
        wr_en          = 1'b1;
        wr_data.timed  = timed;
        wr_data.delta  = ticks;
        wr_data.thread = thr;
      end
      S_RM_SUCC: begin
        wr_en         = 1'b1;
        wr_data.delta = rm_sum[DELTA_W] ? {DELTA_W{1'b1}} : rm_sum[DELTA_W-1:0];
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      mv_wr        <= 1'b0;
      has_pend     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            thr   <= thread_id;
            ticks <= (sleep_ticks == '0) ? DELTA_W'(1) : sleep_ticks;
            timed <= timed_wait;
            pos   <= '0;
            unique case (cmd)
              CMD_PUT: begin
                if (count == CW'(QUEUE_DEPTH)) begin
                  result_valid <= 1'b1;
                  woken_thread <= thread_id;
                  wake_kind    <= KIND_REJECT;
                  last_of_run  <= 1'b1;
                end else if (count == '0) begin
                  state <= S_PUT_NEW;
                end else begin
                  state <= S_PUT_WALK;
                end
              end
              CMD_TICK: begin
                has_pend <= 1'b0;
                if (count != '0) begin
                  state <= S_TK_SCAN;
                end
              end
              CMD_REMOVE: begin
                if (count != '0) begin
                  state <= S_RM_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // walk past every entry that wakes strictly earlier
        S_PUT_WALK: begin
          if (ticks > rd_data.delta) begin
            ticks <= ticks - rd_data.delta;
            pos   <= pos_inc;
            if (pos_inc == count) begin
              state <= S_PUT_NEW;
            end
          end else begin
            stop       <= rd_data;
            src        <= AW'(count - CW'(1));
            dst        <= count[AW-1:0];
            rem        <= count - pos_inc;
            mv_up      <= 1'b0;
            after_move <= S_PUT_SUCC;
            state      <= S_MOVE;
          end
        end

        // copy rem slots, one read and one write per cycle
        S_MOVE: begin
          if (rem != '0) begin
            mv_wr  <= 1'b1;
            mv_dst <= dst;
            src    <= mv_up ? src + AW'(1) : src - AW'(1);
            dst    <= mv_up ? dst + AW'(1) : dst - AW'(1);
            rem    <= rem - CW'(1);
          end else begin
            mv_wr <= 1'b0;
            if (!mv_wr) begin
              state <= after_move;
            end
          end
        end

        S_PUT_SUCC: begin
          state <= S_PUT_NEW;
        end

        S_PUT_NEW: begin
          count <= count + CW'(1);
          state <= S_IDLE;
        end

        // wake leading entries; each result is sent once the next is known
        S_TK_SCAN: begin
          if (tk_wake) begin
            if (has_pend) begin
              result_valid <= 1'b1;
              woken_thread <= pend.thread;
              wake_kind    <= pend.timed ? KIND_TIMEOUT : KIND_WAKE;
              last_of_run  <= 1'b0;
            end
            pend     <= rd_data;
            has_pend <= 1'b1;
            pos      <= pos_inc;
            if (pos_inc == count) begin
              state <= S_TK_FIN;
            end
          end else begin
            // first entry that stays queued: the pending wake ends the run
            if (has_pend) begin
              result_valid <= 1'b1;
              woken_thread <= pend.thread;
              wake_kind    <= pend.timed ? KIND_TIMEOUT : KIND_WAKE;
              last_of_run  <= 1'b1;
            end
            has_pend <= 1'b0;
            state    <= S_TK_FIN;
          end
        end

        // final result when the queue ran empty, then close the gap
        S_TK_FIN: begin
          if (has_pend) begin
            result_valid <= 1'b1;
            woken_thread <= pend.thread;
            wake_kind    <= pend.timed ? KIND_TIMEOUT : KIND_WAKE;
            last_of_run  <= 1'b1;
          end
          has_pend <= 1'b0;
          count    <= count - pos;
          if ((pos != '0) && (pos != count)) begin
            src        <= pos[AW-1:0];
            dst        <= '0;
            rem        <= count - pos;
            mv_up      <= 1'b1;
            after_move <= S_IDLE;
            state      <= S_MOVE;
          end else begin
            state <= S_IDLE;
          end
        end

        // search for the first entry of the thread
        S_RM_SCAN: begin
          if (rd_data.thread == thr) begin
            found_delta <= rd_data.delta;
            if (pos_inc == count) begin
              count <= count - CW'(1);
              state <= S_IDLE;
            end else begin
              state <= S_RM_SUCC;
            end
          end else begin
            pos <= pos_inc;
            if (pos_inc == count) begin
              state <= S_IDLE;
            end
          end
        end

        // successor now sits at pos; shift the rest up by one
        S_RM_SUCC: begin
          count <= count - CW'(1);
          if (pos_inc2 != count) begin
            src        <= pos_inc2[AW-1:0];
            dst        <= pos_inc[AW-1:0];
            rem        <= count - pos_inc2;
            mv_up      <= 1'b1;
            after_move <= S_IDLE;
            state      <= S_MOVE;
          end else begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/sdq_checker.sv
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks of the sleep queue: result runs, reject results and
// result timing against accepted commands.
// ----------------------------------------------------------------------------
module sdq_checker
  import sdq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [1:0]          cmd,
  input logic                result_valid,
  input logic [1:0]          wake_kind,
  input logic                last_of_run
);

  // a reject is a run of its own
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (wake_kind == KIND_REJECT) |-> last_of_run)
    else $error("reject result not marked last");

  // a reject comes in the cycle after an accepted put
  a_reject_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && (wake_kind == KIND_REJECT) |->
      $past(start && !busy && (cmd == CMD_PUT)))
    else $error("reject without a put transfer");

  // wake runs are contiguous until the last result
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |=> result_valid)
    else $error("gap inside a wake run");

  // results only come from a command in progress
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy) || $past(start))
    else $error("result with no command in progress");

endmodule

bind sleep_delta_queue_core sdq_checker u_sdq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .wake_kind    (wake_kind),
  .last_of_run  (last_of_run)
);

### tb/sdq_wake_checker.sv
// ----------------------------------------------------------------------------
// sdq_wake_checker
// Watches the command and result ports of the sleep queue core, keeps its own
// delta-ordered copy of the queue, and compares every result strobe against
// the oldest predicted wake or reject.
// ----------------------------------------------------------------------------
module sdq_wake_checker
  import sdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SDQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          cmd,
  input  logic [THREAD_W-1:0] thread_id,
  input  logic [DELTA_W-1:0]  sleep_ticks,
  input  logic                timed_wait,
  input  logic                result_valid,
  input  logic [THREAD_W-1:0] woken_thread,
  input  logic [1:0]          wake_kind,
  input  logic                last_of_run,
  output int                  outstanding,
  output int                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result
  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [1:0]          kind;
    logic                last;
  } wake_t;

  wake_t pending_wakes[$];

  // shadow copy of the queue, head at index 0
  logic [THREAD_W-1:0] sh_thread [QUEUE_DEPTH];
  logic [DELTA_W-1:0]  sh_delta  [QUEUE_DEPTH];
  logic                sh_timed  [QUEUE_DEPTH];
  int                  sh_count = 0;
  int                  errors   = 0;

  // close the gap left by the entry at pos
  task automatic unlink_slot(input int pos);
    for (int k = pos; k + 1 < sh_count; k++) begin
      sh_thread[k] = sh_thread[k+1];
      sh_delta[k]  = sh_delta[k+1];
      sh_timed[k]  = sh_timed[k+1];
    end
    sh_count--;
  endtask

  // ordered insert; a full queue rejects with a single result
  task automatic sleep_insert(input logic [THREAD_W-1:0] thr, input logic [DELTA_W-1:0] ticks,
                              input logic timed);
    int                 pos;
    logic [DELTA_W-1:0] rem;
    wake_t              w;
    if (sh_count >= QUEUE_DEPTH) begin
      w = '{thread: thr, kind: KIND_REJECT, last: 1'b1};
      pending_wakes.push_back(w);
      return;
    end
    // zero ticks sleeps for one
    rem = (ticks == '0) ? DELTA_W'(1) : ticks;
    pos = 0;
    while (pos < sh_count && rem > sh_delta[pos]) begin
      rem = rem - sh_delta[pos];
      pos++;
    end
    for (int k = sh_count; k > pos; k--) begin
      sh_thread[k] = sh_thread[k-1];
      sh_delta[k]  = sh_delta[k-1];
      sh_timed[k]  = sh_timed[k-1];
    end
    sh_count++;
    sh_thread[pos] = thr;
    sh_delta[pos]  = rem;
    sh_timed[pos]  = timed;
    if (pos + 1 < sh_count) sh_delta[pos+1] = sh_delta[pos+1] - rem;
  endtask

  // one tick: count down the head, wake leading zero-delta entries
  task automatic tick_wakeups();
    int    n;
    wake_t w;
    if (sh_count == 0) return;
    if (sh_delta[0] != '0) sh_delta[0] = sh_delta[0] - 1'b1;
    n = 0;
    while (sh_count > 0 && sh_delta[0] == '0 && n < SDQ_MAX_WAKES) begin
      w.thread = sh_thread[0];
      w.kind   = sh_timed[0] ? KIND_TIMEOUT : KIND_WAKE;
      unlink_slot(0);
      n++;
      // last of the run when nothing further wakes on this tick
      w.last = (sh_count == 0) || (sh_delta[0] != '0) || (n == SDQ_MAX_WAKES);
      pending_wakes.push_back(w);
    end
  endtask

  // drop the entry nearest the head; its delta moves to the successor
  task automatic remove_thread(input logic [THREAD_W-1:0] thr);
    logic [DELTA_W:0] sum;
    for (int pos = 0; pos < sh_count; pos++) begin
      if (sh_thread[pos] == thr) begin
        if (pos + 1 < sh_count) begin
          sum = {1'b0, sh_delta[pos+1]} + {1'b0, sh_delta[pos]};
          sh_delta[pos+1] = sum[DELTA_W] ? '1 : sum[DELTA_W-1:0];
        end
        unlink_slot(pos);
        return;
      end
    end
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_wake();
    wake_t w;
    if (pending_wakes.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual thread %0d kind %0d last %0d",
               $time, woken_thread, wake_kind, last_of_run);
      return;
    end
    w = pending_wakes.pop_front();
    if (woken_thread !== w.thread) begin
      errors++;
      $display("%0t: woken_thread expected %0d actual %0d", $time, w.thread, woken_thread);
    end
    if (wake_kind !== w.kind) begin
      errors++;
      $display("%0t: wake_kind expected %0d actual %0d", $time, w.kind, wake_kind);
    end
    if (last_of_run !== w.last) begin
      errors++;
      $display("%0t: last_of_run expected %0d actual %0d", $time, w.last, last_of_run);
    end
  endtask

  // results of an earlier command are checked before a new command is predicted
  always @(posedge clk) begin
    if (rst) begin
      sh_count = 0;
      pending_wakes.delete();
    end else begin
      if (result_valid) check_wake();
      if (start && !busy) begin
        case (cmd)
          CMD_PUT:    sleep_insert(thread_id, sleep_ticks, timed_wait);
          CMD_TICK:   tick_wakeups();
          CMD_REMOVE: remove_thread(thread_id);
          default: ;
        endcase
      end
    end
    outstanding <= pending_wakes.size();
    fail_count  <= errors;
  end

endmodule

### tb/tb_sleep_delta_queue_core.sv
// ----------------------------------------------------------------------------
// tb_sleep_delta_queue_core
// Drives puts, ticks and removes into the sleep queue core: a directed run
// over empty, duplicate, same-time, full and extreme cases, then random
// traffic in three pacing phases. A checker beside the core predicts and
// compares every wake; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_sleep_delta_queue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sdq_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         N_RANDOM     = 300;
  localparam int         DRAIN_CYCLES = 2 * SDQ_DEPTH_DEF + 12;
  localparam int         QUIET_LIMIT  = 4000;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          cmd;
  logic [THREAD_W-1:0] thread_id;
  logic [DELTA_W-1:0]  sleep_ticks;
  logic                timed_wait;
  logic                result_valid;
  logic [THREAD_W-1:0] woken_thread;
  logic [1:0]          wake_kind;
  logic                last_of_run;
  int                  outstanding;
  int                  fail_count;
  int                  quiet_cycles = 0;

  always #5 clk = ~clk;

  sleep_delta_queue_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .thread_id    (thread_id),
    .sleep_ticks  (sleep_ticks),
    .timed_wait   (timed_wait),
    .result_valid (result_valid),
    .woken_thread (woken_thread),
    .wake_kind    (wake_kind),
    .last_of_run  (last_of_run)
  );

  sdq_wake_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .thread_id    (thread_id),
    .sleep_ticks  (sleep_ticks),
    .timed_wait   (timed_wait),
    .result_valid (result_valid),
    .woken_thread (woken_thread),
    .wake_kind    (wake_kind),
    .last_of_run  (last_of_run),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // present one command and hold it until the transfer
  task automatic send_cmd(input logic [1:0] c, input logic [THREAD_W-1:0] thr,
                          input logic [DELTA_W-1:0] ticks, input logic tw);
    start       <= 1'b1;
    cmd         <= c;
    thread_id   <= thr;
    sleep_ticks <= ticks;
    timed_wait  <= tw;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every predicted result has arrived
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int                  idle_pct;
    int                  roll;
    int                  burst_left;
    logic [1:0]          op;
    logic [THREAD_W-1:0] thr;
    logic [DELTA_W-1:0]  ticks;

    rst         = 1'b1;
    start       = 1'b0;
    cmd         = CMD_PUT;
    thread_id   = '0;
    sleep_ticks = '0;
    timed_wait  = 1'b0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, ignored commands
    send_cmd(CMD_TICK,   8'h33, 16'h0000, 1'b0);
    send_cmd(CMD_REMOVE, 8'h33, 16'h0000, 1'b0);
    send_cmd(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
    // zero ticks, same wake time, longest sleep, duplicate thread
    send_cmd(CMD_PUT,    8'h00, 16'h0000, 1'b0);
    send_cmd(CMD_PUT,    8'hFF, 16'h0001, 1'b1);
    send_cmd(CMD_PUT,    8'hA5, 16'hFFFF, 1'b1);
    send_cmd(CMD_PUT,    8'h5A, 16'h0003, 1'b0);
    send_cmd(CMD_PUT,    8'h5A, 16'h0003, 1'b0);
    send_cmd(CMD_TICK,   8'h00, 16'h0000, 1'b0);
    send_cmd(CMD_REMOVE, 8'h5A, 16'h0000, 1'b0);
    // fill to capacity, reject one, then wake the whole batch on one tick
    for (int k = 0; k < 14; k++) send_cmd(CMD_PUT, THREAD_W'(16 + k), 16'h0001, k[0]);
    send_cmd(CMD_PUT,    8'hC3, 16'h8000, 1'b1);
    send_cmd(CMD_TICK,   8'h00, 16'h0000, 1'b0);

    // random traffic in three pacing phases
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3 || i == 2 * N_RANDOM / 3) wait_drained();
      idle_pct = (i < N_RANDOM / 3) ? 8 : (i < 2 * N_RANDOM / 3) ? 86 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      // occasional put bursts push the queue to full
      if (burst_left == 0 && $urandom_range(0, 99) < 3) burst_left = 18;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
        burst_left--;
        op = CMD_PUT;
      end else if (roll < 45) begin
        op = CMD_PUT;
      end else if (roll < 80) begin
        op = CMD_TICK;
      end else if (roll < 95) begin
        op = CMD_REMOVE;
      end else begin
        op = CMD_UNUSED;
      end
      // small id pool so removes hit and duplicates occur
      thr = ($urandom_range(0, 99) < 80) ? THREAD_W'($urandom_range(0, 7))
                                         : THREAD_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 70) ticks = DELTA_W'($urandom_range(0, 6));
      else if (roll < 90) ticks = DELTA_W'($urandom_range(7, 40));
      else ticks = DELTA_W'($urandom_range(0, 65535));
      send_cmd(op, thr, ticks, 1'($urandom_range(0, 1)));
    end

    // drain, then allow for a late stray result
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sdq_pkg.sv
rtl/sdq_ram.sv
rtl/sleep_delta_queue_core.sv
rtl/sdq_checker.sv
tb/sdq_wake_checker.sv
tb/tb_sleep_delta_queue_core.sv
